>>> hw/rtl/refcounted_lru_tag_cache_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tag cache
// Concurrent checks clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_LRU_TAG_CACHE_DEFINES_SVH
`define REFCOUNTED_LRU_TAG_CACHE_DEFINES_SVH

// same-cycle implication
`define RLC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RLC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/rlc_pkg.sv
// ----------------------------------------------------------------------------
// rlc_pkg
// Shared types and codes of the reference-counted LRU tag cache.
// ----------------------------------------------------------------------------
package rlc_pkg;

    localparam int KEY_W       = 32;
    localparam int STAMP_W     = 32;
    localparam int IDX_OUT_W   = 7;
    localparam int USERS_OUT_W = 8;
    localparam int STATUS_W    = 3;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_HIT      = 3'd0;
    localparam t_status ST_REFILL   = 3'd1;
    localparam t_status ST_FULL     = 3'd2;
    localparam t_status ST_RELEASED = 3'd3;
    localparam t_status ST_REL_ERR  = 3'd4;

    localparam logic MODE_ACQUIRE = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_REL,
        S_DONE
    } t_state;

    // control from the sequencer to the victim tracker
    typedef struct packed {
        logic clear;
        logic sample;
        logic cand;
    } t_vic_ctrl;

    typedef struct packed {
        t_status                 status;
        logic [IDX_OUT_W-1:0]    entry_index;
        logic [USERS_OUT_W-1:0]  users;
    } t_result;

endpackage

>>> hw/rtl/rlc_ifs.sv
// ----------------------------------------------------------------------------
// Tag cache channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rlc_req_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [rlc_pkg::KEY_W-1:0]     file_key;
    logic [rlc_pkg::KEY_W-1:0]     file_version;
    logic [rlc_pkg::IDX_OUT_W-1:0] release_index;

    modport source (output valid, mode, file_key, file_version, release_index, input ready);
    modport sink   (input valid, mode, file_key, file_version, release_index, output ready);
endinterface

interface rlc_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [rlc_pkg::STATUS_W-1:0]    status;
    logic [rlc_pkg::IDX_OUT_W-1:0]   entry_index;
    logic [rlc_pkg::USERS_OUT_W-1:0] users;

    modport source (output valid, status, entry_index, users, input ready);
    modport sink   (input valid, status, entry_index, users, output ready);
endinterface

>>> hw/rtl/rlc_ram.sv
// ----------------------------------------------------------------------------
// rlc_ram
// Simple dual-port entry memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module rlc_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 105,
    parameter int AW    = 7
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;

endmodule

>>> hw/rtl/rlc_victim.sv
// ----------------------------------------------------------------------------
// rlc_victim
// Tracks the oldest free entry seen so far during a scan.
// ----------------------------------------------------------------------------
module rlc_victim #(
    parameter int IW = 7
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rlc_pkg::t_vic_ctrl           i_ctrl,
    input  logic [IW-1:0]                i_idx,
    input  logic [rlc_pkg::STAMP_W-1:0]  i_stamp,
    output logic                         o_have,
    output logic [IW-1:0]                o_idx,
    output logic [rlc_pkg::STAMP_W-1:0]  o_stamp
);

    logic                        r_have;
    logic [IW-1:0]               r_idx;
    logic [rlc_pkg::STAMP_W-1:0] r_stamp;
    logic                        take_cur;

    // strict compare keeps the lowest index on equal stamps
    always_comb begin
        take_cur = i_ctrl.cand && (!r_have || (i_stamp < r_stamp));
        o_have   = r_have || i_ctrl.cand;
        o_idx    = take_cur ? i_idx   : r_idx;
        o_stamp  = take_cur ? i_stamp : r_stamp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_have <= 1'b0;
        end else if (i_ctrl.sample) begin
            r_have <= o_have;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.sample && take_cur) begin
            r_idx   <= i_idx;
            r_stamp <= i_stamp;
        end
    end

endmodule

>>> hw/rtl/refcounted_lru_tag_cache.sv
// ----------------------------------------------------------------------------
// refcounted_lru_tag_cache
// Fully associative tag cache with LRU refill and per-entry user counts.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                      | handshake
//  i_req    | in  | mode, file_key, file_version, release_index  | valid/ready
//  o_rsp    | out | status, entry_index, users                   | valid/ready
//
//  Acquire: one entry read per cycle from the entry memory; a hit at index i
//  ends the scan there, a miss scans all ENTRIES entries before the result.
//  Release: the entry is read and its count decremented if nonzero (an out-of-range index skips the read).
//  After reset a clearing pass over all entries initializes the memory;
//  no request is taken until it ends. One request is in work at a time; a new
//  one is taken while the previous result waits in the output register.
// ----------------------------------------------------------------------------
`include "refcounted_lru_tag_cache_defines.svh"

module refcounted_lru_tag_cache #(
    parameter int ENTRIES   = 128,
    parameter int USER_BITS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rlc_req_if.sink   i_req,
    rlc_rsp_if.source o_rsp
);

    localparam int IW = $clog2(ENTRIES);
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    typedef struct packed {
        logic                        valid;
        logic [rlc_pkg::KEY_W-1:0]   key;
        logic [rlc_pkg::KEY_W-1:0]   version;
        logic [rlc_pkg::STAMP_W-1:0] stamp;
        logic [USER_BITS-1:0]        users;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);
    localparam logic [USER_BITS-1:0] USERS_MAX = {USER_BITS{1'b1}};

    rlc_pkg::t_state             r_state, n_state;
    logic [IW-1:0]               r_addr, n_addr;
    logic                        r_issue_done, n_issue_done;
    logic [rlc_pkg::STAMP_W-1:0] r_clock, n_clock;
    rlc_pkg::t_result            r_res, n_res;
    logic                        r_q_vld;
    logic [IW-1:0]               r_q_idx;
    logic [rlc_pkg::KEY_W-1:0]   r_key;
    logic [rlc_pkg::KEY_W-1:0]   r_ver;
    logic [IW-1:0]               r_rel_idx;
    logic                        r_out_vld;
    rlc_pkg::t_result            r_out;

    logic                        rd_en;
    logic [IW-1:0]               rd_addr;
    logic [ENTRY_W-1:0]          rd_data;
    logic                        wr_en;
    logic [IW-1:0]               wr_addr;
    t_entry                      wr_data;
    t_entry                      q;
    logic                        accept;
    logic                        in_range;
    logic                        key_match;
    logic                        hit;
    logic                        cand;
    logic                        out_free;
    logic [USER_BITS-1:0]        users_inc;
    logic [USER_BITS-1:0]        users_dec;
    rlc_pkg::t_vic_ctrl          vic_ctrl;
    logic                        vic_have;
    logic [IW-1:0]               vic_idx;
    logic [rlc_pkg::STAMP_W-1:0] vic_stamp;

    rlc_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (ENTRY_W),
        .AW    (IW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    rlc_victim #(
        .IW (IW)
    ) u_victim (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (vic_ctrl),
        .i_idx   (r_q_idx),
        .i_stamp (q.stamp),
        .o_have  (vic_have),
        .o_idx   (vic_idx),
        .o_stamp (vic_stamp)
    );

    assign q         = rd_data;
    assign accept    = i_req.valid && i_req.ready;
    assign in_range  = {25'd0, i_req.release_index} < 32'(ENTRIES);
    assign key_match = q.valid && (q.key == r_key);
    assign hit       = key_match && (q.version == r_ver);
    // a stale-version match is skipped as a refill candidate
    assign cand      = (q.users == '0) && !key_match;
    assign out_free  = !r_out_vld || o_rsp.ready;
    assign users_inc = (q.users == USERS_MAX) ? q.users : q.users + USER_BITS'(1);
    assign users_dec = q.users - USER_BITS'(1);

    assign i_req.ready       = (r_state == rlc_pkg::S_IDLE);
    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.status      = r_out.status;
    assign o_rsp.entry_index = r_out.entry_index;
    assign o_rsp.users       = r_out.users;

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_issue_done = r_issue_done;
        n_clock      = r_clock;
        n_res        = r_res;
        rd_en        = 1'b0;
        rd_addr      = r_addr;
        wr_en        = 1'b0;
        wr_addr      = r_addr;
        wr_data      = q;
        vic_ctrl     = '0;

        case (r_state)
            rlc_pkg::S_CLEAR: begin
                wr_en         = 1'b1;
                wr_data       = '0;
                wr_data.stamp = rlc_pkg::STAMP_W'(r_addr);
                n_addr        = r_addr + IW'(1);
                if (r_addr == LAST) begin
                    n_addr  = '0;
                    n_state = rlc_pkg::S_IDLE;
                end
            end
            rlc_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    vic_ctrl.clear = 1'b1;
                    if (i_req.mode == rlc_pkg::MODE_RELEASE) begin
                        if (in_range) begin
                            rd_en   = 1'b1;
                            rd_addr = IW'(i_req.release_index);
                            n_state = rlc_pkg::S_REL;
                        end else begin
                            n_res.status      = rlc_pkg::ST_REL_ERR;
                            n_res.entry_index = i_req.release_index;
                            n_res.users       = '0;
                            n_state           = rlc_pkg::S_DONE;
                        end
                    end else begin
                        // start the scan at entry zero
                        rd_en        = 1'b1;
                        rd_addr      = '0;
                        n_addr       = IW'(1);
                        n_issue_done = 1'b0;
                        n_state      = rlc_pkg::S_SCAN;
                    end
                end
            end
            rlc_pkg::S_SCAN: begin
                if (!r_issue_done) begin
                    rd_en   = 1'b1;
                    rd_addr = r_addr;
                    n_addr  = r_addr + IW'(1);
                    if (r_addr == LAST) begin
                        n_issue_done = 1'b1;
                    end
                end
                if (r_q_vld) begin
                    if (hit) begin
                        wr_en             = 1'b1;
                        wr_addr           = r_q_idx;
                        wr_data.users     = users_inc;
                        wr_data.stamp     = r_clock;
                        n_clock           = r_clock + 32'd1;
                        n_res.status      = rlc_pkg::ST_HIT;
                        n_res.entry_index = rlc_pkg::IDX_OUT_W'(r_q_idx);
                        n_res.users       = rlc_pkg::USERS_OUT_W'(users_inc);
                        n_state           = rlc_pkg::S_DONE;
                    end else begin
                        vic_ctrl.sample = 1'b1;
                        vic_ctrl.cand   = cand;
                        if (r_q_idx == LAST) begin
                            if (vic_have) begin
                                wr_en             = 1'b1;
                                wr_addr           = vic_idx;
                                wr_data.valid     = 1'b1;
                                wr_data.key       = r_key;
                                wr_data.version   = r_ver;
                                wr_data.stamp     = r_clock;
                                wr_data.users     = USER_BITS'(1);
                                n_clock           = r_clock + 32'd1;
                                n_res.status      = rlc_pkg::ST_REFILL;
                                n_res.entry_index = rlc_pkg::IDX_OUT_W'(vic_idx);
                                n_res.users       = rlc_pkg::USERS_OUT_W'(1);
                            end else begin
                                n_res.status      = rlc_pkg::ST_FULL;
                                n_res.entry_index = '0;
                                n_res.users       = '0;
                            end
                            n_state = rlc_pkg::S_DONE;
                        end
                    end
                end
            end
            rlc_pkg::S_REL: begin
                n_res.entry_index = rlc_pkg::IDX_OUT_W'(r_rel_idx);
                if (q.users == '0) begin
                    n_res.status = rlc_pkg::ST_REL_ERR;
                    n_res.users  = '0;
                end else begin
                    wr_en         = 1'b1;
                    wr_addr       = r_rel_idx;
                    wr_data.users = users_dec;
                    n_res.status  = rlc_pkg::ST_RELEASED;
                    n_res.users   = rlc_pkg::USERS_OUT_W'(users_dec);
                end
                n_state = rlc_pkg::S_DONE;
            end
            rlc_pkg::S_DONE: begin
                // hold until the output register frees up
                if (out_free) begin
                    n_state = rlc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rlc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rlc_pkg::S_CLEAR;
            r_addr       <= '0;
            r_issue_done <= 1'b0;
            r_clock      <= 32'(ENTRIES);
            r_q_vld      <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_addr       <= n_addr;
            r_issue_done <= n_issue_done;
            r_clock      <= n_clock;
            r_q_vld      <= rd_en;
            if ((r_state == rlc_pkg::S_DONE) && out_free) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res   <= n_res;
        r_q_idx <= rd_addr;
        if (accept) begin
            r_key     <= i_req.file_key;
            r_ver     <= i_req.file_version;
            r_rel_idx <= IW'(i_req.release_index);
        end
        if ((r_state == rlc_pkg::S_DONE) && out_free) begin
            r_out <= r_res;
        end
    end

    `RLC_ASSERT_NXT(a_clock_step, wr_en && (r_state == rlc_pkg::S_SCAN), r_clock == $past(r_clock) + 32'd1, "access clock did not advance on hit or refill")
    `RLC_ASSERT_IMP(a_no_idle_write, r_state == rlc_pkg::S_IDLE, !wr_en, "entry memory written while idle")
    `RLC_ASSERT_IMP(a_refill_one_user, o_rsp.valid && (o_rsp.status == rlc_pkg::ST_REFILL), o_rsp.users == rlc_pkg::USERS_OUT_W'(1), "refilled entry does not hold one user")
    `RLC_ASSERT_IMP(a_full_zero, o_rsp.valid && (o_rsp.status == rlc_pkg::ST_FULL), (o_rsp.entry_index == '0) && (o_rsp.users == '0), "no-free-entry result not zeroed")

endmodule

>>> verif/refcounted_lru_tag_cache_checker.sv
// ----------------------------------------------------------------------------
// Tag cache result checker
// Watches the request and response channels, keeps its own copy of the tag
// table, predicts each response in order and compares it field by field.
// ----------------------------------------------------------------------------
module rlc_result_checker
    import rlc_pkg::*;
#(
    parameter int ENTRIES   = 128,
    parameter int USER_BITS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rlc_req_if   i_req,
    rlc_rsp_if   i_rsp,
    output int   o_mismatches,
    output int   o_outstanding,
    output int   o_hits,
    output int   o_refills,
    output int   o_full,
    output int   o_released,
    output int   o_rel_err
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [USER_BITS-1:0] USERS_MAX = '1;

    // shadow of the tag table
    logic                 tag_valid [ENTRIES];
    logic [KEY_W-1:0]     tag_key   [ENTRIES];
    logic [KEY_W-1:0]     tag_ver   [ENTRIES];
    logic [STAMP_W-1:0]   tag_stamp [ENTRIES];
    logic [USER_BITS-1:0] tag_users [ENTRIES];
    logic [STAMP_W-1:0]   use_clock;

    t_result expected_results [$];
    t_result want;
    int      mismatch_cnt;
    int      hit_cnt;
    int      refill_cnt;
    int      full_cnt;
    int      released_cnt;
    int      rel_err_cnt;

    assign o_mismatches  = mismatch_cnt;
    assign o_hits        = hit_cnt;
    assign o_refills     = refill_cnt;
    assign o_full        = full_cnt;
    assign o_released    = released_cnt;
    assign o_rel_err     = rel_err_cnt;

    initial begin
        mismatch_cnt  = 0;
        hit_cnt       = 0;
        refill_cnt    = 0;
        full_cnt      = 0;
        released_cnt  = 0;
        rel_err_cnt   = 0;
        o_outstanding = 0;
    end

    task automatic report_mismatch(input string what);
        mismatch_cnt++;
        $display("ERROR @%0t ns: %s", $time, what);
    endtask

    function automatic t_result predict_acquire(input logic [KEY_W-1:0] key,
                                                input logic [KEY_W-1:0] ver);
        t_result            res;
        logic               have_victim;
        int                 victim;
        logic [STAMP_W-1:0] oldest;
        res         = '0;
        have_victim = 1'b0;
        victim      = 0;
        oldest      = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (tag_valid[i] && tag_key[i] == key) begin
                // a stale version is neither a hit nor a refill candidate
                if (tag_ver[i] == ver) begin
                    if (tag_users[i] != USERS_MAX) begin
                        tag_users[i] = tag_users[i] + 1'b1;
                    end
                    tag_stamp[i]    = use_clock;
                    use_clock       = use_clock + 1'b1;
                    res.status      = ST_HIT;
                    res.entry_index = IDX_OUT_W'(i);
                    res.users       = USERS_OUT_W'(tag_users[i]);
                    return res;
                end
            end else if (tag_users[i] == '0 && (!have_victim || tag_stamp[i] < oldest)) begin
                have_victim = 1'b1;
                oldest      = tag_stamp[i];
                victim      = i;
            end
        end
        if (!have_victim) begin
            res.status = ST_FULL;
            return res;
        end
        tag_valid[victim] = 1'b1;
        tag_key[victim]   = key;
        tag_ver[victim]   = ver;
        tag_users[victim] = USER_BITS'(1);
        tag_stamp[victim] = use_clock;
        use_clock         = use_clock + 1'b1;
        res.status        = ST_REFILL;
        res.entry_index   = IDX_OUT_W'(victim);
        res.users         = USERS_OUT_W'(1);
        return res;
    endfunction

    function automatic t_result predict_release(input logic [IDX_OUT_W-1:0] idx);
        t_result res;
        res             = '0;
        res.entry_index = idx;
        if (int'(idx) >= ENTRIES || tag_users[idx] == '0) begin
            res.status = ST_REL_ERR;
            return res;
        end
        tag_users[idx] = tag_users[idx] - 1'b1;
        res.status     = ST_RELEASED;
        res.users      = USERS_OUT_W'(tag_users[idx]);
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                tag_valid[i] = 1'b0;
                tag_key[i]   = '0;
                tag_ver[i]   = '0;
                tag_stamp[i] = STAMP_W'(i);
                tag_users[i] = '0;
            end
            use_clock = STAMP_W'(ENTRIES);
            expected_results.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("response with no request waiting: status %0d",
                                              i_rsp.status));
                end else begin
                    want = expected_results.pop_front();
                    if (i_rsp.status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  i_rsp.status, want.status));
                    if (i_rsp.entry_index !== want.entry_index)
                        report_mismatch($sformatf("entry_index got %0d want %0d (status %0d)",
                                                  i_rsp.entry_index, want.entry_index,
                                                  want.status));
                    if (i_rsp.users !== want.users)
                        report_mismatch($sformatf("users got %0d want %0d (entry %0d)",
                                                  i_rsp.users, want.users, want.entry_index));
                    case (want.status)
                        ST_HIT:      hit_cnt++;
                        ST_REFILL:   refill_cnt++;
                        ST_FULL:     full_cnt++;
                        ST_RELEASED: released_cnt++;
                        default:     rel_err_cnt++;
                    endcase
                end
            end
            if (i_req.valid && i_req.ready) begin
                if (i_req.mode == MODE_ACQUIRE)
                    expected_results.push_back(predict_acquire(i_req.file_key,
                                                               i_req.file_version));
                else
                    expected_results.push_back(predict_release(i_req.release_index));
            end
        end
        o_outstanding <= expected_results.size();
    end

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// Tag cache testbench
// Drives directed and random acquire/release traffic into the tag cache
// under several idle and back-pressure settings; the checker predicts and
// compares every response, and this top reports the verdict.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import rlc_pkg::*;

    localparam int ENTRIES      = 128;
    localparam int USER_BITS    = 8;
    localparam int RANDOM_ITEMS = 1050;
    localparam int POOL_SIZE    = 40;
    localparam int STALL_LIMIT  = 5000;
    localparam logic [KEY_W-1:0] SAT_KEY = 32'h5A5A_A5A5;
    localparam logic [KEY_W-1:0] SAT_VER = 32'h0F0F_F0F0;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rlc_req_if req_ch ();
    rlc_rsp_if rsp_ch ();

    int chk_mismatches;
    int chk_outstanding;
    int chk_hits;
    int chk_refills;
    int chk_full;
    int chk_released;
    int chk_rel_err;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;
    int quiet_cycles   = 0;

    logic [IDX_OUT_W-1:0] held_entries [$];
    logic [KEY_W-1:0]     pool_key [POOL_SIZE];
    logic [KEY_W-1:0]     pool_ver [POOL_SIZE];

    refcounted_lru_tag_cache #(
        .ENTRIES   (ENTRIES),
        .USER_BITS (USER_BITS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    rlc_result_checker #(
        .ENTRIES   (ENTRIES),
        .USER_BITS (USER_BITS)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_ch),
        .i_rsp         (rsp_ch),
        .o_mismatches  (chk_mismatches),
        .o_outstanding (chk_outstanding),
        .o_hits        (chk_hits),
        .o_refills     (chk_refills),
        .o_full        (chk_full),
        .o_released    (chk_released),
        .o_rel_err     (chk_rel_err)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // track entries held by earlier acquires so releases are mostly legal
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready &&
            (rsp_ch.status == ST_HIT || rsp_ch.status == ST_REFILL)) begin
            held_entries.push_back(rsp_ch.entry_index);
        end
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles, %0d responses outstanding",
                     quiet_cycles, chk_outstanding);
            $display("Mismatches found");
            $finish;
        end
    end

    // call at a falling edge; returns at the falling edge after the transfer
    task automatic send_request(input logic mode, input logic [KEY_W-1:0] key,
                                input logic [KEY_W-1:0] ver,
                                input logic [IDX_OUT_W-1:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.mode          <= mode;
        req_ch.file_key      <= key;
        req_ch.file_version  <= ver;
        req_ch.release_index <= idx;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic request_acquire(input logic [KEY_W-1:0] key, input logic [KEY_W-1:0] ver);
        send_request(MODE_ACQUIRE, key, ver, IDX_OUT_W'($urandom_range(127)));
    endtask

    task automatic request_release(input logic [IDX_OUT_W-1:0] idx);
        send_request(MODE_RELEASE, $urandom, $urandom, idx);
    endtask

    task automatic release_held();
        int                   pick;
        logic [IDX_OUT_W-1:0] idx;
        if (held_entries.size() == 0) begin
            idx = IDX_OUT_W'($urandom_range(127));
        end else begin
            pick = $urandom_range(held_entries.size() - 1);
            idx  = held_entries[pick];
            held_entries.delete(pick);
        end
        request_release(idx);
    endtask

    task automatic pool_acquire();
        int               k;
        int               roll;
        logic [KEY_W-1:0] ver;
        k    = $urandom_range(POOL_SIZE - 1);
        roll = $urandom_range(99);
        // occasionally the object changes; sometimes probe with a stale version
        if (roll < 10) pool_ver[k] = $urandom;
        ver = (roll >= 10 && roll < 18) ? (pool_ver[k] ^ 32'h1) : pool_ver[k];
        request_acquire(pool_key[k], ver);
    endtask

    // stop driving and let every outstanding response drain
    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        wait (chk_outstanding == 0);
        @(negedge i_clk);
    endtask

    initial begin
        int                   base;
        int                   done_random;
        int                   phase;
        int                   kind;
        int                   n;
        logic                 sat_done;
        logic                 fill_done;
        logic [IDX_OUT_W-1:0] sat_idx;

        i_rst_n              <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.mode          <= MODE_ACQUIRE;
        req_ch.file_key      <= '0;
        req_ch.file_version  <= '0;
        req_ch.release_index <= '0;
        sat_done             = 1'b0;
        fill_done            = 1'b0;

        pool_key[0] = '0;
        pool_ver[0] = '0;
        pool_key[1] = '1;
        pool_ver[1] = '1;
        for (int k = 2; k < POOL_SIZE; k++) begin
            pool_key[k] = $urandom;
            pool_ver[k] = $urandom;
        end

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // key zero must miss on the empty table, then hit
        request_acquire(32'h0, 32'h0);
        request_acquire(32'h0, 32'h0);
        request_acquire(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // same key, new version: refill elsewhere
        request_acquire(32'h0, 32'hFFFF_FFFF);
        request_release(7'd0);
        request_release(7'd0);
        request_release(7'd0);
        // valid entry with count zero still hits
        request_acquire(32'h0, 32'h0);
        request_release(7'h7F);
        request_release(7'd1);
        request_acquire(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        request_acquire(32'hAAAA_AAAA, 32'h5555_5555);
        request_acquire(32'h5555_5555, 32'hAAAA_AAAA);
        request_acquire(32'hAAAA_AAAA, 32'hAAAA_AAAA);
        request_release(7'd2);
        request_release(7'd2);
        request_acquire(32'h0, 32'hFFFF_FFFF);
        request_release(7'h55);
        request_release(7'h2A);
        request_release(7'd0);
        // stale match on two entries with one of them free
        request_acquire(32'h0, 32'h1);

        base        = items_sent;
        done_random = 0;
        while (done_random < RANDOM_ITEMS) begin
            phase = done_random * 4 / RANDOM_ITEMS;
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            if (!sat_done && done_random >= 150) begin
                // drive one entry into count saturation
                repeat (258) request_acquire(SAT_KEY, SAT_VER);
                drain_responses();
                sat_idx = held_entries[$];
                for (int i = held_entries.size() - 1; i >= 0; i--) begin
                    if (held_entries[i] == sat_idx) held_entries.delete(i);
                end
                repeat (8) request_release(sat_idx);
                sat_done = 1'b1;
            end else if (!fill_done && done_random >= 520) begin
                // fill the table until no entry is free, then give most back
                repeat (140) request_acquire($urandom, $urandom);
                repeat (6) pool_acquire();
                drain_responses();
                n = held_entries.size() * 3 / 4;
                repeat (n) release_held();
                fill_done = 1'b1;
            end else begin
                kind = $urandom_range(99);
                n    = $urandom_range(3, 12);
                if (kind < 50) begin
                    repeat (n) begin
                        if (held_entries.size() > 0 && $urandom_range(99) < 30)
                            release_held();
                        else
                            pool_acquire();
                    end
                end else if (kind < 68) begin
                    repeat (n) release_held();
                end else if (kind < 82) begin
                    repeat (n) send_request(1'($urandom_range(1)), $urandom, $urandom,
                                            IDX_OUT_W'($urandom_range(127)));
                end else begin
                    repeat (n) request_acquire($urandom, $urandom);
                end
            end
            done_random = items_sent - base;
        end

        req_ch.valid <= 1'b0;
        wait (chk_outstanding == 0);
        repeat (ENTRIES + 10) @(posedge i_clk);

        $display("Covered %0d requests: %0d hits, %0d refills, %0d table-full, %0d releases,",
                 items_sent, chk_hits, chk_refills, chk_full, chk_released);
        $display("%0d release errors, under four idle/stall settings", chk_rel_err);
        if (chk_mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
